// ===== hw/rtl/mp2_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2_pkg: shared types and constants of the 2x2 max pooling block
// Sample type, window entry carried from front to back, register indexes.
// ----------------------------------------------------------------------------
package mp2_pkg;

	// Sample and result field widths
	localparam int SAMPLE_W     = 16;
	localparam int OUT_IDX_W    = 8;
	localparam int DIM_CFG_W    = 9;
	localparam int STRIDE_CFG_W = 2;
	localparam int CFG_DATA_W   = 9;
	localparam int CFG_INDEX_W  = 1;

	// Register reset values
	localparam logic [DIM_CFG_W-1:0]    DIM_RESET    = 9'd28;
	localparam logic [STRIDE_CFG_W-1:0] STRIDE_RESET = 2'd2;

	// Stride codes with special handling (zero behaves as one)
	localparam logic [STRIDE_CFG_W-1:0] STRIDE_ZERO  = 2'd0;
	localparam logic [STRIDE_CFG_W-1:0] STRIDE_ONE   = 2'd1;
	localparam logic [STRIDE_CFG_W-1:0] STRIDE_TWO   = 2'd2;
	localparam logic [STRIDE_CFG_W-1:0] STRIDE_THREE = 2'd3;

	// Window queue depth between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_DIM = 1'b0,
		REG_STRIDE    = 1'b1
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One complete window, scan order (0,0), (1,0), (0,1), (1,1)
	typedef struct packed {
		sample_t                ul;
		sample_t                ll;
		sample_t                ur;
		sample_t                lr;
		logic [OUT_IDX_W-1:0]   orow;
		logic [OUT_IDX_W-1:0]   ocol;
		logic                   last;
	} win_t;

endpackage

// ===== hw/rtl/mp2_ram.sv =====
// ----------------------------------------------------------------------------
// mp2_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module mp2_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/mp2_front.sv =====
// ----------------------------------------------------------------------------
// mp2_front: pixel intake, position tracking and window classification
// Tracks row and column, reads and writes the line buffer, keeps the left
// and upper-left pixels and pushes each complete window into the queue.
// ----------------------------------------------------------------------------
module mp2_front
	import mp2_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [DIM_CFG_W-1:0]    image_dim,
	input  logic [STRIDE_CFG_W-1:0] stride,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  sample_t                 sample,
	input  logic                    start_plane,
	input  logic                    q_full,
	output logic                    q_push,
	output win_t                    q_data
);

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int DW1   = DIM_W + 1;
	localparam int EW    = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;

	// Position counters with their divide-by-three shadows
	logic [CW-1:0] row_q, col_q, row3_q, col3_q;
	logic [1:0]    rowm3_q, colm3_q;
	logic [CW-1:0] row_n, col_n, row3_n, col3_n;
	logic [1:0]    rowm3_n, colm3_n;

	logic [CW-1:0] r, c, r3, c3;
	logic [1:0]    rm3, cm3;
	logic [DW1-1:0] r_x, c_x, dim_x, st_x;
	logic [EW-1:0]  dim_ext, dim_cl;
	logic [STRIDE_CFG_W-1:0] st_eff;
	logic           phase_ok, emit, last;
	logic [CW-1:0]  orow, ocol;
	logic [CW+7:0]  orow_x, ocol_x;
	logic           accept;

	// Stage 1 and neighbor pixels
	logic                 valid_s1, emit_s1, last_s1, adv_s1;
	sample_t              px_s1;
	logic [OUT_IDX_W-1:0] orow_s1, ocol_s1;
	sample_t              ul_q, left_q;
	logic [SAMPLE_W-1:0]  above;

	assign adv_s1   = valid_s1 & (~emit_s1 | ~q_full);
	assign in_stall = valid_s1 & ~adv_s1;
	assign accept   = in_valid & ~in_stall;

	// Clamp dimension and map stride zero to one
	always_comb begin
		dim_ext = EW'(image_dim);
		if (dim_ext < EW'(2)) begin
			dim_cl = EW'(2);
		end else if (dim_ext > EW'(MAX_DIM)) begin
			dim_cl = EW'(MAX_DIM);
		end else begin
			dim_cl = dim_ext;
		end
		st_eff = (stride == STRIDE_ZERO) ? STRIDE_ONE : stride;
		dim_x  = DW1'(dim_cl[DIM_W-1:0]);
		st_x   = DW1'(st_eff);
	end

	// Classify the incoming pixel
	always_comb begin
		r   = start_plane ? '0 : row_q;
		c   = start_plane ? '0 : col_q;
		r3  = start_plane ? '0 : row3_q;
		c3  = start_plane ? '0 : col3_q;
		rm3 = start_plane ? 2'd0 : rowm3_q;
		cm3 = start_plane ? 2'd0 : colm3_q;
		r_x = DW1'(r);
		c_x = DW1'(c);

		case (st_eff)
			STRIDE_TWO: begin
				phase_ok = r[0] & c[0];
				orow     = r >> 1;
				ocol     = c >> 1;
			end
			STRIDE_THREE: begin
				phase_ok = (rm3 == 2'd1) && (cm3 == 2'd1);
				orow     = r3;
				ocol     = c3;
			end
			default: begin
				phase_ok = 1'b1;
				orow     = r - CW'(1);
				ocol     = c - CW'(1);
			end
		endcase

		emit = (r_x < dim_x) && (c_x < dim_x) && (r != '0) && (c != '0) && phase_ok;
		// Last window: the next origin would no longer fit
		last = ((r_x + st_x) >= dim_x) && ((c_x + st_x) >= dim_x);

		orow_x = {8'd0, orow};
		ocol_x = {8'd0, ocol};
	end

	// Advance position, wrap at the plane edge
	always_comb begin
		row_n   = r;
		row3_n  = r3;
		rowm3_n = rm3;
		if ((c_x + DW1'(1)) >= dim_x) begin
			col_n   = '0;
			col3_n  = '0;
			colm3_n = 2'd0;
			if ((r_x + DW1'(1)) >= dim_x) begin
				row_n   = '0;
				row3_n  = '0;
				rowm3_n = 2'd0;
			end else begin
				row_n = r + CW'(1);
				if (rm3 == 2'd2) begin
					rowm3_n = 2'd0;
					row3_n  = r3 + CW'(1);
				end else begin
					rowm3_n = rm3 + 2'd1;
				end
			end
		end else begin
			col_n = c + CW'(1);
			if (cm3 == 2'd2) begin
				colm3_n = 2'd0;
				col3_n  = c3 + CW'(1);
			end else begin
				colm3_n = cm3 + 2'd1;
				col3_n  = c3;
			end
			if (r_x >= dim_x) begin
				row_n   = '0;
				row3_n  = '0;
				rowm3_n = 2'd0;
			end
		end
	end

	// Position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			row3_q  <= '0;
			col3_q  <= '0;
			rowm3_q <= 2'd0;
			colm3_q <= 2'd0;
		end else if (accept) begin
			row_q   <= row_n;
			col_q   <= col_n;
			row3_q  <= row3_n;
			col3_q  <= col3_n;
			rowm3_q <= rowm3_n;
			colm3_q <= colm3_n;
		end
	end

	// Line buffer: read the pixel above, store the current one
	mp2_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_DIM)
	) u_line (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (c),
		.wr_data (sample),
		.rd_en   (accept),
		.rd_addr (c),
		.rd_data (above)
	);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= sample;
			emit_s1 <= emit;
			last_s1 <= last;
			orow_s1 <= orow_x[OUT_IDX_W-1:0];
			ocol_s1 <= ocol_x[OUT_IDX_W-1:0];
		end
	end

	// Shift neighbors as each pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q   <= '0;
			left_q <= '0;
		end else if (adv_s1) begin
			ul_q   <= sample_t'(above);
			left_q <= px_s1;
		end
	end

	// Hand complete windows to the queue
	assign q_push      = valid_s1 & emit_s1 & ~q_full;
	assign q_data.ul   = ul_q;
	assign q_data.ll   = left_q;
	assign q_data.ur   = sample_t'(above);
	assign q_data.lr   = px_s1;
	assign q_data.orow = orow_s1;
	assign q_data.ocol = ocol_s1;
	assign q_data.last = last_s1;

`ifndef SYNTHESIS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(px_s1) && $stable(above))
		else $error("stage 1 lost its pixel while held");
`endif

endmodule

// ===== hw/rtl/mp2_queue.sv =====
// ----------------------------------------------------------------------------
// mp2_queue: short window queue between front and back
// Register-based FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module mp2_queue
	import mp2_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  win_t push_data,
	output logic full,
	input  logic pop,
	output win_t pop_data,
	output logic not_empty
);

	win_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("window queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("window queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("window queue count missed a transfer");
`endif

endmodule

// ===== hw/rtl/mp2_back.sv =====
// ----------------------------------------------------------------------------
// mp2_back: window maximum and argmax, result register
// Picks the first maximum of each queued window and holds the result
// until the consumer takes it.
// ----------------------------------------------------------------------------
module mp2_back
	import mp2_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  win_t                 q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sample_t              pooled_max,
	output logic [OUT_IDX_W-1:0] out_row,
	output logic [OUT_IDX_W-1:0] out_col,
	output logic                 max_row_offset,
	output logic                 max_col_offset,
	output logic                 plane_done
);

	logic       out_valid_q;
	sample_t    max_q;
	logic [OUT_IDX_W-1:0] row_q, col_q;
	logic       row_off_q, col_off_q, done_q;

	logic       pick_ll, pick_lr, pick_right;
	sample_t    max_left, max_right, max_win;
	logic [1:0] best;

	// Pairwise compare, earlier scan position wins ties
	always_comb begin
		pick_ll    = q_data.ll > q_data.ul;
		max_left   = pick_ll ? q_data.ll : q_data.ul;
		pick_lr    = q_data.lr > q_data.ur;
		max_right  = pick_lr ? q_data.lr : q_data.ur;
		pick_right = max_right > max_left;
		max_win    = pick_right ? max_right : max_left;
		best       = pick_right ? {1'b1, pick_lr} : {1'b0, pick_ll};
	end

	assign q_pop = q_valid & (~out_valid_q | ~out_stall);

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			max_q     <= max_win;
			row_q     <= q_data.orow;
			col_q     <= q_data.ocol;
			row_off_q <= best[0];
			col_off_q <= best[1];
			done_q    <= q_data.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign pooled_max     = max_q;
	assign out_row        = row_q;
	assign out_col        = col_q;
	assign max_row_offset = row_off_q;
	assign max_col_offset = col_off_q;
	assign plane_done     = done_q;

`ifndef SYNTHESIS
	a_max_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> max_q >= $past(q_data.ul) && max_q >= $past(q_data.ll) &&
			max_q >= $past(q_data.ur) && max_q >= $past(q_data.lr))
		else $error("pooled maximum below a window sample");
`endif

endmodule

// ===== hw/rtl/max_pool_2x2_argmax.sv =====
// ----------------------------------------------------------------------------
// max_pool_2x2_argmax: streaming 2x2 max pooling with argmax
// Pools square Q8.8 planes in raster order with stride 1 to 3, reporting
// window maximum, output position, argmax offset and plane end.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in      | in  | in_valid / in_stall  | sample, start_plane
//  out     | out | out_valid / out_stall| pooled_max, out_row, out_col,
//          |     |                      | max_row_offset, max_col_offset,
//          |     |                      | plane_done
//  cfg     | in  | cfg_wr_en            | cfg_index, cfg_wr_data
//
//  One pixel per cycle while the window queue has room; the pixel that completes
//  a window is registered in stage 1, the window is then written to the window
//  queue and its result to the argmax register, where it is offered.
//  The line buffer has one write and one read port, both used once per pixel.
//  Reset clears position, neighbor pixels and control; no clearing pass.
//  A stalled output fills the two-entry window queue before the input stalls.
// ----------------------------------------------------------------------------
module max_pool_2x2_argmax
	import mp2_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sample_t                sample,
	input  logic                   start_plane,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sample_t                pooled_max,
	output logic [OUT_IDX_W-1:0]   out_row,
	output logic [OUT_IDX_W-1:0]   out_col,
	output logic                   max_row_offset,
	output logic                   max_col_offset,
	output logic                   plane_done
);

	logic [DIM_CFG_W-1:0]    image_dim_q;
	logic [STRIDE_CFG_W-1:0] stride_q;

	logic q_full, q_push, q_pop, q_not_empty;
	win_t q_wr_data, q_rd_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_dim_q <= DIM_RESET;
			stride_q    <= STRIDE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_DIM: image_dim_q <= cfg_wr_data[DIM_CFG_W-1:0];
				REG_STRIDE:    stride_q    <= cfg_wr_data[STRIDE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	mp2_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_dim   (image_dim_q),
		.stride      (stride_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.start_plane (start_plane),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	mp2_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.not_empty (q_not_empty)
	);

	mp2_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_not_empty),
		.q_data         (q_rd_data),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pooled_max     (pooled_max),
		.out_row        (out_row),
		.out_col        (out_col),
		.max_row_offset (max_row_offset),
		.max_col_offset (max_col_offset),
		.plane_done     (plane_done)
	);

endmodule

// ===== tb/sv/tb_max_pool_2x2_argmax.sv =====
// ----------------------------------------------------------------------------
// tb_max_pool_2x2_argmax: self-checking testbench of the 2x2 max pooling block
// Streams Q8.8 pixel planes through the block under random sender bursts and
// receiver stalls. A scoreboard class rebuilds every window from its own line
// memory and compares each pooled result field by field, in order.
// ----------------------------------------------------------------------------
module tb_max_pool_2x2_argmax;
	import mp2_pkg::*;

	localparam int POOL_MAX_DIM = 256;
	localparam int WINDOW_SIZE  = 2;
	localparam int MAX_REPORTS  = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_PAUSE  = 8;
	localparam int RAND_ITEMS   = 450;
	localparam int DIR_ITEMS    = 22;
	localparam int PHASE_CAP    = 64;

	// Directed planes at size 2, stride 1: all-minimum tie, lower-left tie win,
	// upper-right tie win over lower-right, lower-right win, restart mid-plane
	localparam sample_t DIR_PX [DIR_ITEMS] = '{
		16'h8000, 16'h8000, 16'h8000, 16'h8000,
		16'h0001, 16'h0007, 16'h0007, 16'h0005,
		16'h0000, 16'h7fff, 16'hffff, 16'h7fff,
		16'hfffb, 16'hfffc, 16'hfffd, 16'hfffe,
		16'h0009, 16'h0009, 16'h0003, 16'h0002, 16'h0001, 16'h0000
	};
	localparam bit DIR_SOP [DIR_ITEMS] = '{
		1, 0, 0, 0,  0, 0, 0, 0,  1, 0, 0, 0,  0, 0, 0, 0,  1, 0, 1, 0, 0, 0
	};

	typedef struct packed {
		sample_t                max_val;
		logic [OUT_IDX_W-1:0]   row;
		logic [OUT_IDX_W-1:0]   col;
		logic                   row_off;
		logic                   col_off;
		logic                   last;
	} pooled_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// Window predictor and in-order store of the pooled results still due
	class pool_scoreboard;
		sample_t                 line_mem [POOL_MAX_DIM];
		sample_t                 left_px;
		sample_t                 upper_left_px;
		int unsigned             row_pos;
		int unsigned             col_pos;
		logic [DIM_CFG_W-1:0]    dim_reg;
		logic [STRIDE_CFG_W-1:0] stride_reg;
		pooled_t                 expected_windows [$];
		int                      mismatches;
		int                      pixels_seen;
		int                      windows_checked;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			left_px         = '0;
			upper_left_px   = '0;
			row_pos         = 0;
			col_pos         = 0;
			dim_reg         = DIM_RESET;
			stride_reg      = STRIDE_RESET;
			mismatches      = 0;
			pixels_seen     = 0;
			windows_checked = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] word);
			if (idx == REG_IMAGE_DIM) begin
				dim_reg = word[DIM_CFG_W-1:0];
			end else begin
				stride_reg = word[STRIDE_CFG_W-1:0];
			end
		endfunction

		// Clamp plane size to what the window and line memory allow
		function int unsigned eff_dim();
			if (dim_reg < WINDOW_SIZE) return WINDOW_SIZE;
			if (dim_reg > POOL_MAX_DIM) return POOL_MAX_DIM;
			return dim_reg;
		endfunction

		function int pending();
			return expected_windows.size();
		endfunction

		// Advance the raster position by one pixel; queue the window it completes
		function void note_pixel(sample_t px, logic sop);
			int unsigned dim;
			int unsigned step;
			int unsigned r;
			int unsigned c;
			int unsigned best;
			int unsigned orow;
			int unsigned ocol;
			int unsigned odim;
			sample_t     above;
			sample_t     win [4];
			pooled_t     w;
			dim  = eff_dim();
			step = (stride_reg == STRIDE_ZERO) ? 1 : stride_reg;
			pixels_seen++;
			if (sop) begin
				row_pos = 0;
				col_pos = 0;
			end
			r     = row_pos;
			c     = col_pos;
			above = line_mem[c % POOL_MAX_DIM];
			if (r < dim && c < dim && r >= 1 && c >= 1 &&
			    (r - 1) % step == 0 && (c - 1) % step == 0) begin
				// scan order: upper-left, lower-left, upper-right, lower-right
				win[0] = upper_left_px;
				win[1] = left_px;
				win[2] = above;
				win[3] = px;
				best = 0;
				for (int k = 1; k < 4; k++) begin
					if (win[k] > win[best]) best = k;
				end
				orow      = (r - 1) / step;
				ocol      = (c - 1) / step;
				odim      = (dim - WINDOW_SIZE) / step + 1;
				w.max_val = win[best];
				w.row     = orow[OUT_IDX_W-1:0];
				w.col     = ocol[OUT_IDX_W-1:0];
				w.row_off = best[0];
				w.col_off = best[1];
				w.last    = (orow == odim - 1) && (ocol == odim - 1);
				expected_windows.push_back(w);
			end
			upper_left_px                = above;
			left_px                      = px;
			line_mem[c % POOL_MAX_DIM]   = px;
			if (c + 1 >= dim) begin
				col_pos = 0;
				row_pos = (r + 1 >= dim) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				if (r >= dim) row_pos = 0;
			end
		endfunction

		// Compare one transferred result against the oldest window due
		function void check_window(pooled_t got);
			pooled_t want;
			if (expected_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected pooled result: max %0d row %0d col %0d",
						got.max_val, got.row, got.col);
				end
				return;
			end
			want = expected_windows.pop_front();
			windows_checked++;
			if (got.max_val !== want.max_val || got.row !== want.row ||
			    got.col !== want.col || got.row_off !== want.row_off ||
			    got.col_off !== want.col_off || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("window %0d: expected max %0d row %0d col %0d off (%0d,%0d) last %0d",
						windows_checked, want.max_val, want.row, want.col,
						want.row_off, want.col_off, want.last);
					$display("           got      max %0d row %0d col %0d off (%0d,%0d) last %0d",
						got.max_val, got.row, got.col, got.row_off, got.col_off, got.last);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	cfg_reg_t               cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	sample_t                sample;
	logic                   start_plane;
	logic                   out_valid;
	logic                   out_stall;
	sample_t                pooled_max;
	logic [OUT_IDX_W-1:0]   out_row;
	logic [OUT_IDX_W-1:0]   out_col;
	logic                   max_row_offset;
	logic                   max_col_offset;
	logic                   plane_done;

	pool_scoreboard sb;
	int             burst_left   = 0;
	int             holds_asked  = 0;
	int             quiet_cycles = 0;
	int             settings_used = 0;

	max_pool_2x2_argmax #(
		.MAX_DIM(POOL_MAX_DIM)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.start_plane   (start_plane),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pooled_max    (pooled_max),
		.out_row       (out_row),
		.out_col       (out_col),
		.max_row_offset(max_row_offset),
		.max_col_offset(max_col_offset),
		.plane_done    (plane_done)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Note transfers on both channels at the rising edge; watch for a hang
	always @(posedge clk) begin : transfer_monitor
		pooled_t got;
		bit      activity;
		if (arst_n) begin
			activity = 1'b0;
			if (out_valid && !out_stall) begin
				got.max_val = pooled_max;
				got.row     = out_row;
				got.col     = out_col;
				got.row_off = max_row_offset;
				got.col_off = max_col_offset;
				got.last    = plane_done;
				sb.check_window(got);
				activity = 1'b1;
			end
			if (in_valid && !in_stall) begin
				sb.note_pixel(sample, start_plane);
				activity = 1'b1;
			end
			quiet_cycles = activity ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, sb.pending());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver stall pattern, with long hold-offs on request
	initial begin : receiver_stall
		rx_mode_t rx_mode;
		int       mode_left;
		int       hold_left;
		int       holds_done;
		bit       stall_now;
		out_stall  = 1'b0;
		rx_mode    = RX_FREE;
		mode_left  = 0;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				stall_now = 1'b1;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				stall_now = 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (rx_mode)
					RX_FREE:     stall_now = 1'b0;
					RX_LIGHT:    stall_now = ($urandom_range(0, 3) == 0);
					RX_HEAVY:    stall_now = ($urandom_range(0, 3) != 0);
					default:     stall_now = ((mode_left / 3) % 2) == 1;
				endcase
			end
			out_stall <= stall_now;
		end
	end

	// Offer one pixel, inserting sender gaps between bursts; return after transfer
	task automatic push_pixel(input sample_t px, input logic sop);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
			                                         : $urandom_range(1, 30);
		end
		burst_left--;
		in_valid    <= 1'b1;
		sample      <= px;
		start_plane <= sop;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Stream random pixels, biased to extremes and small values that tie
	task automatic run_items(input int n, input int noise_pct, input bit first_sop,
	                         input int hold_at);
		sample_t px;
		bit      sop;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0:       px = 16'h8000;
				1:       px = 16'h7fff;
				2, 3:    px = sample_t'(int'($urandom_range(0, 6)) - 3);
				default: px = sample_t'($urandom);
			endcase
			sop = (i == 0 && first_sop) || ($urandom_range(0, 99) < noise_pct);
			if (i == hold_at) holds_asked++;
			push_pixel(px, sop);
		end
	endtask

	// Hold the input until every due result is out, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	// Raise the write enable for one register; the caller drops it
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] word);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= word;
		@(negedge clk);
		sb.set_reg(idx, word);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] dim_word,
	                         input logic [CFG_DATA_W-1:0] stride_word);
		bit stride_first;
		stride_first = $urandom_range(0, 1);
		write_reg(stride_first ? REG_STRIDE : REG_IMAGE_DIM,
			stride_first ? stride_word : dim_word);
		write_reg(stride_first ? REG_IMAGE_DIM : REG_STRIDE,
			stride_first ? dim_word : stride_word);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int                    phase_idx;
		int                    total_items;
		int                    n;
		int unsigned           d;
		int                    noise;
		logic [CFG_DATA_W-1:0] dim_word;
		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_IMAGE_DIM;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		sample      = '0;
		start_plane = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: size word zero clamps to 2, stride zero acts as 1
		configure(9'd0, {7'($urandom), STRIDE_ZERO});
		for (int i = 0; i < DIR_ITEMS; i++) push_pixel(DIR_PX[i], DIR_SOP[i]);
		total_items = DIR_ITEMS;

		// Fixed and random phases, each starting a fresh plane at a new setting;
		// stop near the item budget once the fixed phases are done
		phase_idx = 0;
		while (phase_idx < 5 || total_items < RAND_ITEMS) begin
			drain_results();
			if (phase_idx == 1) begin
				// dense results, then a long receiver hold-off to back up the input
				configure(9'd3, {7'($urandom), STRIDE_ONE});
				run_items(54, 0, 1'b1, 12);
				total_items += 54;
			end else if (phase_idx == 2) begin
				// largest plane: size word clamps to 256; one row plus part of the next
				configure(9'd511, {7'($urandom), 2'($urandom_range(0, 1))});
				n = 256 + $urandom_range(8, 24);
				run_items(n, 0, 1'b1, 260);
				total_items += n;
			end else if (phase_idx == 4) begin
				// stride three, then shrink the plane mid-row without a new start mark
				configure(9'd9, {7'($urandom), STRIDE_THREE});
				run_items(50, 0, 1'b1, -1);
				drain_results();
				write_reg(REG_IMAGE_DIM, 9'd4);
				cfg_wr_en <= 1'b0;
				run_items(40, 0, 1'b0, -1);
				total_items += 90;
			end else begin
				case ($urandom_range(0, 11))
					0:       dim_word = 9'd0;
					1:       dim_word = 9'd1;
					2:       dim_word = 9'd2;
					3:       dim_word = 9'd3;
					4:       dim_word = 9'd4;
					5:       dim_word = 9'd5;
					6:       dim_word = 9'd6;
					7:       dim_word = 9'd7;
					8:       dim_word = 9'd8;
					9:       dim_word = 9'd9;
					10:      dim_word = 9'd13;
					default: dim_word = 9'd28;
				endcase
				configure(dim_word, {7'($urandom), 2'($urandom_range(0, 3))});
				d = sb.eff_dim();
				if (d <= 9) begin
					n = d * d * $urandom_range(1, 3);
					// truncate some sequences part way into a plane
					if ($urandom_range(0, 3) == 0) n += $urandom_range(1, d * d - 1);
				end else begin
					n = $urandom_range(3 * d, 5 * d);
				end
				// keep each random phase short
				if (n > PHASE_CAP) n = PHASE_CAP;
				noise = ($urandom_range(0, 9) < 7) ? 0 : 3;
				run_items(n, noise, 1'b1, -1);
				total_items += n;
			end
			phase_idx++;
		end
		drain_results();

		$display("Covered %0d pixels and %0d pooled windows over %0d register settings;",
			sb.pixels_seen, sb.windows_checked, settings_used);
		$display("strides 0 to 3, planes 2 to 256, unmarked planes, restarts and a resize.");
		if (sb.mismatches > 0) $display("%0d results mismatched or came unexpectedly",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
